@@ rtl/core/html_escape_bounded_top_defines.svh @@
// Assertion macros for the escaper. Assertions are sampled on clk.
`ifndef HTML_ESCAPE_BOUNDED_TOP_DEFINES_SVH
`define HTML_ESCAPE_BOUNDED_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define HESC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, in reset too.
`define HESC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HESC_ASSERT(lbl, prop, msg)
`define HESC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/hesc_pkg.sv @@
package hesc_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int OUT_COUNT_W     = 16;
	localparam logic [15:0] CAPACITY_RESET = 16'd4096;

	typedef enum logic [2:0] {
		ESC_NONE,
		ESC_LT,
		ESC_GT,
		ESC_QUOT,
		ESC_APOS,
		ESC_AMP
	} esc_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_COUNT = 2'd2
	} kind_t;

	// One queued job for the back end
	typedef struct packed {
		logic [7:0]             in_byte;
		esc_t                   esc;
		logic                   data;      // expansion fits, emit it
		logic                   term;      // emit terminator after data
		logic                   cnt_only;  // capacity zero, count result only
		logic [OUT_COUNT_W-1:0] base;      // count before this byte
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic esc_t esc_classify(input logic [7:0] b);
		esc_t e;
		unique case (b)
			"<":     e = ESC_LT;
			">":     e = ESC_GT;
			"\"":    e = ESC_QUOT;
			"'":     e = ESC_APOS;
			"&":     e = ESC_AMP;
			default: e = ESC_NONE;
		endcase
		return e;
	endfunction

	function automatic logic [2:0] esc_len(input esc_t e);
		logic [2:0] n;
		unique case (e)
			ESC_LT, ESC_GT:     n = 3'd4;
			ESC_QUOT, ESC_APOS: n = 3'd6;
			ESC_AMP:            n = 3'd5;
			default:            n = 3'd1;
		endcase
		return n;
	endfunction

	// Byte idx of an escape sequence; zero for plain bytes
	function automatic logic [7:0] esc_char(input esc_t e, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (e)
			ESC_LT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "l";
					3'd2:    c = "t";
					3'd3:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ESC_GT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "g";
					3'd2:    c = "t";
					3'd3:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ESC_QUOT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "q";
					3'd2:    c = "u";
					3'd3:    c = "o";
					3'd4:    c = "t";
					3'd5:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ESC_APOS: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "#";
					3'd2:    c = "0";
					3'd3:    c = "3";
					3'd4:    c = "9";
					3'd5:    c = ";";
					default: c = 8'h00;
				endcase
			end
			ESC_AMP: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "a";
					3'd2:    c = "m";
					3'd3:    c = "p";
					3'd4:    c = ";";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/html_escape_bounded_top.sv @@
// An input transfer reaches its first result through a queue entry, then the output register.
// Throughput: one plain byte per cycle unless in_stall or out_stall holds it; an escaped byte
// holds the back end for its 4 to 6 results, and a terminator or count-only result adds one;
// the 4-entry queue absorbs bursts. The back end emits one result per cycle unless stalled,
// set by its single output register. Reset clears the running count, the truncation flag,
// the queue and the output valid, and sets out_capacity to 4096.
module html_escape_bounded_top #(
	parameter int COUNT_BITS  = hesc_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = hesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  item_kind,
	output logic        run_end,
	output logic [15:0] written_count
);

	logic [15:0]      out_capacity_q;
	logic             push;
	logic             pop;
	hesc_pkg::cmd_t   wr_cmd;
	hesc_pkg::cmd_t   head;
	hesc_pkg::qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= hesc_pkg::CAPACITY_RESET;
		end else if (cfg_wen) begin
			out_capacity_q <= cfg_wdata;
		end
	end

	hesc_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_capacity (out_capacity_q),
		.in_valid     (in_valid),
		.in_byte      (in_byte),
		.last_byte    (last_byte),
		.qstat        (qstat),
		.in_stall     (in_stall),
		.push         (push),
		.cmd          (wr_cmd)
	);

	hesc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	hesc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.item_kind     (item_kind),
		.run_end       (run_end),
		.written_count (written_count)
	);

endmodule

@@ rtl/core/hesc_front.sv @@
module hesc_front #(
	parameter int COUNT_BITS = hesc_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       out_capacity,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              last_byte,
	input  hesc_pkg::qstat_t  qstat,
	output logic              in_stall,
	output logic              push,
	output hesc_pkg::cmd_t    cmd
);

	localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
	localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COUNT_BITS;

	logic [COUNT_BITS-1:0] bw_q;
	logic                  trunc_q;

	logic             accept;
	hesc_pkg::esc_t   esc;
	logic [2:0]       len;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap;
	logic [CMP_W-1:0] sum;
	logic             cap_zero;
	logic             fits;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	assign esc      = hesc_pkg::esc_classify(in_byte);
	assign len      = hesc_pkg::esc_len(esc);
	assign cap_ext  = CMP_W'(out_capacity);
	assign cap      = (cap_ext < LIMIT) ? cap_ext : LIMIT;
	assign sum      = CMP_W'(bw_q) + CMP_W'(len);
	assign cap_zero = (out_capacity == 16'd0);
	// keep one slot free for the terminator
	assign fits     = !cap_zero && !trunc_q && (sum < cap);

	always_comb begin
		cmd.in_byte  = in_byte;
		cmd.esc      = esc;
		cmd.data     = fits;
		cmd.term     = last_byte && !cap_zero;
		cmd.cnt_only = last_byte && cap_zero;
		cmd.base     = cap_zero ? '0 : hesc_pkg::OUT_COUNT_W'(bw_q);
	end

	// dropped bytes that do not end the string produce nothing
	assign push = accept && (fits || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q    <= '0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				bw_q    <= '0;
				trunc_q <= 1'b0;
			end else if (!cap_zero) begin
				if (fits) begin
					bw_q <= COUNT_BITS'(sum);
				end else begin
					trunc_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/core/hesc_queue.sv @@
`include "html_escape_bounded_top_defines.svh"

module hesc_queue #(
	parameter int DEPTH = hesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hesc_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output hesc_pkg::cmd_t    head,
	output hesc_pkg::qstat_t  qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hesc_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`HESC_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
	`HESC_ASSERT(a_no_overflow, push |-> (count_q < CNT_W'(DEPTH)) || pop, "push into full queue")
	`HESC_ASSERT(a_no_underflow, pop |-> (count_q != '0), "pop from empty queue")

endmodule

@@ rtl/core/hesc_back.sv @@
`include "html_escape_bounded_top_defines.svh"

module hesc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hesc_pkg::cmd_t                  head,
	input  hesc_pkg::qstat_t                qstat,
	output logic                            pop,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [7:0]                      out_byte,
	output logic [1:0]                      item_kind,
	output logic                            run_end,
	output logic [hesc_pkg::OUT_COUNT_W-1:0] written_count
);

	logic [2:0]                       idx_q;
	logic                             out_valid_q;
	logic [7:0]                       byte_q;
	hesc_pkg::kind_t                  kind_q;
	logic                             end_q;
	logic [hesc_pkg::OUT_COUNT_W-1:0] count_q;

	logic                             load;
	logic [2:0]                       len;
	logic                             data_phase;
	logic                             data_last;
	logic                             final_piece;
	logic [7:0]                       nxt_byte;
	hesc_pkg::kind_t                  nxt_kind;
	logic                             nxt_end;
	logic [hesc_pkg::OUT_COUNT_W-1:0] nxt_count;

	assign len        = hesc_pkg::esc_len(head.esc);
	assign data_phase = head.data && (idx_q < len);
	assign data_last  = (idx_q == len - 3'd1);

	always_comb begin
		if (data_phase) begin
			nxt_byte    = (head.esc == hesc_pkg::ESC_NONE) ? head.in_byte
			                                            : hesc_pkg::esc_char(head.esc, idx_q);
			nxt_kind    = hesc_pkg::KIND_DATA;
			nxt_count   = head.base + hesc_pkg::OUT_COUNT_W'(idx_q) + hesc_pkg::OUT_COUNT_W'(1);
			final_piece = data_last && !head.term;
		end else begin
			nxt_byte    = 8'h00;
			nxt_kind    = head.cnt_only ? hesc_pkg::KIND_COUNT : hesc_pkg::KIND_TERM;
			nxt_count   = head.data ? head.base + hesc_pkg::OUT_COUNT_W'(len) : head.base;
			final_piece = 1'b1;
		end
		nxt_end = final_piece;
	end

	// advance when the output register is free or being drained
	assign load = !qstat.empty && (!out_valid_q || !out_stall);
	assign pop  = load && final_piece;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_piece ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= nxt_byte;
			kind_q  <= nxt_kind;
			end_q   <= nxt_end;
			count_q <= nxt_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign item_kind     = kind_q;
	assign run_end       = end_q;
	assign written_count = count_q;

	`HESC_ASSERT(a_term_ends_run, out_valid_q && (kind_q != hesc_pkg::KIND_DATA) |-> end_q, "terminator without run end")
	`HESC_ASSERT(a_count_only_zero, out_valid_q && (kind_q == hesc_pkg::KIND_COUNT) |-> (count_q == '0) && (byte_q == 8'h00), "count-only result not zero")
	`HESC_ASSERT(a_idx_bound, !qstat.empty |-> idx_q <= len, "escape index past sequence")

endmodule

@@ verif/tb_top.sv @@
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;
	localparam int COUNT_SPAN  = 1 << hesc_pkg::COUNT_BITS_DEF;

	typedef struct {
		logic [7:0]      ch;
		hesc_pkg::kind_t kind;
		logic            run_end;
		logic [15:0]     count;
	} esc_result_t;

	typedef struct {
		int              cap;     // negative: leave capacity alone
		logic [7:0]      ch;
		logic            last;
		bit              typed;
		hesc_pkg::kind_t t_kind;
		int              t_count;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  item_kind;
	logic        run_end;
	logic [15:0] written_count;

	esc_result_t escaped_q[$];
	esc_result_t head;
	int cap_model = int'(hesc_pkg::CAPACITY_RESET);
	int written_model = 0;
	bit trunc_model = 1'b0;
	int in_gap_pct = 0;
	int out_stall_pct = 0;
	int n_items = 0, n_results = 0, n_terms = 0, n_counts = 0, n_errors = 0;
	int cycles = 0;

	dir_row_t dir_rows[24] = '{
		'{-1,    "A",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  1},
		'{-1,    8'h00, 1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    8'hFF, 1'b1, 1'b1, hesc_pkg::KIND_TERM,  2},
		'{-1,    "<",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    ">",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "\"",  1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "'",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "&",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "x",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  26},
		'{0,     "a",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "<",   1'b1, 1'b1, hesc_pkg::KIND_COUNT, 0},
		'{1,     "a",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "b",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  0},
		'{5,     "<",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "a",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "b",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  4},
		'{4,     "&",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "a",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "c",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  0},
		'{65535, "\"",  1'b1, 1'b1, hesc_pkg::KIND_TERM,  6},
		'{-1,    "a",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "b",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{-1,    "c",   1'b0, 1'b0, hesc_pkg::KIND_DATA,  0},
		'{2,     "d",   1'b1, 1'b1, hesc_pkg::KIND_TERM,  3}
	};

	int phase_caps[8] = '{3, 0, 17, 65535, 1, 9, 40, 2};

	html_escape_bounded_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.item_kind     (item_kind),
		.run_end       (run_end),
		.written_count (written_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Expand one accepted byte into the results it should produce
	task automatic predict_escape(input logic [7:0] b, input logic l);
		string s;
		logic [7:0] seq[$];
		int cap_eff;
		int added;
		esc_result_t r;
		case (b)
			"<":     s = "&lt;";
			">":     s = "&gt;";
			"\"":    s = "&quot;";
			"'":     s = "&#039;";
			"&":     s = "&amp;";
			default: s = "";
		endcase
		if (s.len() == 0)
			seq.push_back(b);
		else
			for (int i = 0; i < s.len(); i++)
				seq.push_back(s[i]);
		cap_eff = (cap_model < COUNT_SPAN) ? cap_model : COUNT_SPAN;
		added = 0;
		if (cap_model == 0) begin
			if (l) begin
				r = '{8'h00, hesc_pkg::KIND_COUNT, 1'b1, 16'd0};
				escaped_q.push_back(r);
				written_model = 0;
				trunc_model = 1'b0;
			end
			return;
		end
		if (!trunc_model && written_model + seq.size() < cap_eff) begin
			foreach (seq[i]) begin
				written_model++;
				r = '{seq[i], hesc_pkg::KIND_DATA, 1'b0, written_model[15:0]};
				escaped_q.push_back(r);
				added++;
			end
		end else begin
			trunc_model = 1'b1;
		end
		if (l) begin
			r = '{8'h00, hesc_pkg::KIND_TERM, 1'b1, written_model[15:0]};
			escaped_q.push_back(r);
			written_model = 0;
			trunc_model = 1'b0;
		end else if (added > 0) begin
			escaped_q[escaped_q.size() - 1].run_end = 1'b1;
		end
	endtask

	// Called and returns at a falling edge; valid stays high into the next transfer
	task automatic push_byte(input logic [7:0] b, input logic l, input bit typed = 1'b0,
			input hesc_pkg::kind_t t_kind = hesc_pkg::KIND_DATA, input int t_count = 0);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = b;
		last_byte = l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_items++;
		predict_escape(b, l);
		if (typed) begin
			escaped_q[escaped_q.size() - 1].kind = t_kind;
			escaped_q[escaped_q.size() - 1].count = t_count[15:0];
		end
		@(negedge clk);
	endtask

	// Hold the input until every expected result has arrived, then let the back end settle
	task automatic settle(input int extra);
		in_valid = 1'b0;
		while (escaped_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_capacity(input int v);
		settle(SETTLE);
		cfg_wen = 1'b1;
		cfg_wdata = v[15:0];
		@(negedge clk);
		cfg_wen = 1'b0;
		cap_model = v & 16'hFFFF;
	endtask

	always @(negedge clk)
		out_stall = ($urandom_range(99) < out_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (item_kind == hesc_pkg::KIND_TERM)
				n_terms++;
			if (item_kind == hesc_pkg::KIND_COUNT)
				n_counts++;
			if (escaped_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result at cycle %0d: byte %02h kind %0d end %0d count %0d",
						cycles, out_byte, item_kind, run_end, written_count);
			end else begin
				head = escaped_q.pop_front();
				if (out_byte !== head.ch || item_kind !== head.kind ||
						run_end !== head.run_end || written_count !== head.count) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch at cycle %0d: expected byte %02h kind %0d end %0d ",
							"count %0d, got byte %02h kind %0d end %0d count %0d"},
							cycles, head.ch, head.kind, head.run_end, head.count,
							out_byte, item_kind, run_end, written_count);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("timeout after %0d cycles", cycles);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0] b;
		logic l;
		int left_in_str;
		left_in_str = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cap >= 0)
				write_capacity(dir_rows[i].cap);
			push_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].t_kind, dir_rows[i].t_count);
		end

		// Strings run across phase boundaries, so capacity also changes mid-string
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_caps[p]);
			case (p % 4)
				0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
				1: begin in_gap_pct = 55; out_stall_pct = 0;  end
				2: begin in_gap_pct = 0;  out_stall_pct = 55; end
				default: begin in_gap_pct = 30; out_stall_pct = 30; end
			endcase
			repeat (63) begin
				if ($urandom_range(99) < 35) begin
					case ($urandom_range(4))
						0: b = "<";
						1: b = ">";
						2: b = "\"";
						3: b = "'";
						default: b = "&";
					endcase
				end else begin
					b = 8'($urandom);
				end
				if (left_in_str == 0)
					left_in_str = ($urandom_range(9) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 10);
				l = (left_in_str == 1);
				left_in_str--;
				push_byte(b, l);
				if ($urandom_range(39) == 0)
					settle(0);
			end
		end

		settle(SETTLE);
		$display("sent %0d bytes, checked %0d results (%0d terminators, %0d count-only)",
			n_items, n_results, n_terms, n_counts);
		$display("capacities from 0 to 65535 under four idle patterns, %0d mismatches", n_errors);
		if (n_errors == 0 && escaped_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
